@@ src/pcmc_pkg.sv @@
`timescale 1ns / 1ps

package pcmc_pkg;

    // default pixel width
    localparam int PIXEL_BITS_DEF = 32;

    // config register file
    localparam int NUM_CFG    = 8;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int NUM_CHAN   = 4;

    // register indexes; destination masks sit at channel index plus NUM_CHAN
    localparam logic [CFG_IDX_W-1:0] REG_SRC_RED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_GREEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_BLUE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_ALPHA = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DST_RED   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DST_GREEN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DST_BLUE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DST_ALPHA = 3'd7;

    localparam logic [31:0] CFG_RESET [NUM_CFG] = '{
        32'h00FF0000, 32'h0000FF00, 32'h000000FF, 32'hFF000000,
        32'h00FF0000, 32'h0000FF00, 32'h000000FF, 32'hFF000000
    };

endpackage

@@ src/pcmc_lane.sv @@
`timescale 1ns / 1ps

module pcmc_lane import pcmc_pkg::*; #(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF,
    parameter int SW         = $clog2(PIXEL_BITS),
    parameter int LS         = PIXEL_BITS + 3
) (
    input  logic                  aclk,
    input  logic [LS-1:0]         ld,
    input  logic [PIXEL_BITS-1:0] pix,
    input  logic [PIXEL_BITS-1:0] smask,
    input  logic [SW-1:0]         ss,
    input  logic [PIXEL_BITS-1:0] smax,
    input  logic [PIXEL_BITS-1:0] dmax,
    input  logic [PIXEL_BITS-1:0] dmask,
    input  logic [SW-1:0]         ds,
    input  logic                  szero,
    input  logic                  dzero,
    output logic [PIXEL_BITS-1:0] chan_out
);

    localparam int P = PIXEL_BITS;

    logic [P-1:0]   val_reg;
    logic [2*P-1:0] prod_reg;
    logic [P-1:0]   rem_reg [P+1];
    logic [P-1:0]   quo_reg [P+1];
    logic [2*P-1:0] dividend;

    // extract and align the channel
    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            val_reg <= (pix & smask) >> ss;
        end
    end

    // value times destination maximum
    always_ff @(posedge aclk) begin
        if (ld[1]) begin
            prod_reg <= {{P{1'b0}}, val_reg} * {{P{1'b0}}, dmax};
        end
    end

    // add half the divisor for rounding
    assign dividend = prod_reg + {{P{1'b0}}, (smax >> 1)};

    always_ff @(posedge aclk) begin
        if (ld[2]) begin
            rem_reg[0] <= dividend[2*P-1:P];
            quo_reg[0] <= dividend[P-1:0];
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar j = 0; j < P; j++) begin : g_div
        logic [P:0] trial;
        logic       ge;
        logic [P:0] diff;

        assign trial = {rem_reg[j], quo_reg[j][P-1]};
        assign ge    = trial >= {1'b0, smax};
        assign diff  = trial - {1'b0, smax};

        always_ff @(posedge aclk) begin
            if (ld[3+j]) begin
                rem_reg[j+1] <= ge ? diff[P-1:0] : trial[P-1:0];
                quo_reg[j+1] <= {quo_reg[j][P-2:0], ge};
            end
        end
    end

    // place into destination position; zero masks override
    always_comb begin
        if (dzero) begin
            chan_out = '0;
        end else if (szero) begin
            chan_out = dmask;
        end else begin
            chan_out = quo_reg[P] << ds;
        end
    end

endmodule

@@ src/pixel_channel_mask_converter_unit.sv @@
`timescale 1ns / 1ps

// an accepted word passes the input register, the lane stages and the output register to m_tdata
// throughput: one word per cycle while not stalled; the length is set by the restoring divider, one bit per stage
// stalls back up stage by stage, empty stages fill even while the output is held
// reset: synchronous active-low aresetn clears all valid bits and loads the mask defaults
// mask-derived values (shifts, maxima) are registered in the cycle after a register write

module pixel_channel_mask_converter_unit import pcmc_pkg::*; #(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // [31:0] src_pixel
    // output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // [31:0] dst_pixel
    // config port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int P  = PIXEL_BITS;
    localparam int SW = $clog2(PIXEL_BITS);
    localparam int NS = PIXEL_BITS + 5;   // input reg, lane stages, output reg
    localparam int LS = NS - 2;           // stages inside each lane

    // ---------------------------------------------------------------
    // config registers
    // ---------------------------------------------------------------
    logic [31:0]          cfg_reg [NUM_CFG];
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic                 cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[CFG_IDX_W+1:2];
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign prdata  = cfg_reg[cfg_idx];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CFG; i++) begin
                cfg_reg[i] <= CFG_RESET[i];
            end
        end else if (cfg_wr) begin
            cfg_reg[cfg_idx] <= pwdata;
        end
    end

    // ---------------------------------------------------------------
    // per-channel derived values, registered off the config path
    // ---------------------------------------------------------------
    logic [P-1:0]  smask_reg [NUM_CHAN];
    logic [P-1:0]  dmask_reg [NUM_CHAN];
    logic [SW-1:0] ss_reg    [NUM_CHAN];
    logic [SW-1:0] ds_reg    [NUM_CHAN];
    logic [P-1:0]  smax_reg  [NUM_CHAN];
    logic [P-1:0]  dmax_reg  [NUM_CHAN];
    logic          szero_reg [NUM_CHAN];
    logic          dzero_reg [NUM_CHAN];

    logic [P-1:0]  sm_next   [NUM_CHAN];
    logic [P-1:0]  dm_next   [NUM_CHAN];
    logic [SW-1:0] ss_next   [NUM_CHAN];
    logic [SW-1:0] ds_next   [NUM_CHAN];

    always_comb begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            sm_next[c] = cfg_reg[c][P-1:0];
            dm_next[c] = cfg_reg[c+NUM_CHAN][P-1:0];
            ss_next[c] = '0;
            ds_next[c] = '0;
            // lowest set bit: scan downward so the lowest wins
            for (int b = P - 1; b >= 0; b--) begin
                if (sm_next[c][b]) begin
                    ss_next[c] = SW'(b);
                end
                if (dm_next[c][b]) begin
                    ds_next[c] = SW'(b);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            smask_reg[c] <= sm_next[c];
            dmask_reg[c] <= dm_next[c];
            ss_reg[c]    <= ss_next[c];
            ds_reg[c]    <= ds_next[c];
            smax_reg[c]  <= sm_next[c] >> ss_next[c];
            dmax_reg[c]  <= dm_next[c] >> ds_next[c];
            szero_reg[c] <= (sm_next[c] == '0);
            dzero_reg[c] <= (dm_next[c] == '0);
        end
    end

    // ---------------------------------------------------------------
    // valid chain with per-stage ready so bubbles collapse
    // ---------------------------------------------------------------
    logic [NS-1:0] valid_reg;
    logic [NS:0]   ready;

    assign ready[NS] = m_tready;
    for (genvar k = 0; k < NS; k++) begin : g_rdy
        assign ready[k] = ~valid_reg[k] | ready[k+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (ready[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (ready[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign s_tready = ready[0];
    assign m_tvalid = valid_reg[NS-1];

    // input word register
    logic [P-1:0] pix_reg;

    always_ff @(posedge aclk) begin
        if (ready[0]) begin
            pix_reg <= s_tdata[P-1:0];
        end
    end

    // ---------------------------------------------------------------
    // channel lanes
    // ---------------------------------------------------------------
    logic [P-1:0] chan_res [NUM_CHAN];

    for (genvar c = 0; c < NUM_CHAN; c++) begin : g_lane
        pcmc_lane #(
            .PIXEL_BITS (PIXEL_BITS),
            .SW         (SW),
            .LS         (LS)
        ) u_lane (
            .aclk     (aclk),
            .ld       (ready[LS:1]),
            .pix      (pix_reg),
            .smask    (smask_reg[c]),
            .ss       (ss_reg[c]),
            .smax     (smax_reg[c]),
            .dmax     (dmax_reg[c]),
            .dmask    (dmask_reg[c]),
            .ds       (ds_reg[c]),
            .szero    (szero_reg[c]),
            .dzero    (dzero_reg[c]),
            .chan_out (chan_res[c])
        );
    end

    // merge channels into the output word register
    logic [P-1:0] dst_reg;

    always_ff @(posedge aclk) begin
        if (ready[NS-1]) begin
            dst_reg <= chan_res[0] | chan_res[1] | chan_res[2] | chan_res[3];
        end
    end

    assign m_tdata = 32'(dst_reg);

`ifndef SYNTHESIS
    // an accepted word always lands in the input stage
    a_accept_lands : assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> valid_reg[0])
        else $error("accepted word lost at input stage");

    // a stalled stage keeps its word
    a_stage_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[1] && !ready[2] |=> valid_reg[1])
        else $error("stalled stage dropped its word");

    // reset empties the output
    a_reset_empty : assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // an aligned nonzero source maximum is always odd (checked on the red channel)
    a_smax_odd : assert property (@(posedge aclk) disable iff (!aresetn)
        !szero_reg[0] |-> smax_reg[0][0])
        else $error("red source maximum not aligned");
`endif

endmodule
